// ----- hdl/sst_pkg.sv -----
// Shared sizes, codes and types of the swap slot table.
package sst_pkg;

   localparam int SLOTS       = 64;
   localparam int PROCS       = 64;
   localparam int MAX_RESULTS = 64;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int PID_W  = 6;
   localparam int PAGE_W = 32;

   typedef enum logic [1:0] {
      FUNC_STORE  = 2'd0,
      FUNC_LOAD   = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_COPY   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD       = 2'd3
   } status_type;

   typedef struct packed {
      logic [PID_W-1:0]  owner;
      logic [PAGE_W-1:0] page;
   } entry_type;

endpackage

// ----- hdl/sst_req_if.sv -----
// Request channel of the swap slot table: one operation per item.
interface sst_req_if;
   logic                         valid;
   logic                         ready;
   sst_pkg::func_type            func;
   logic [sst_pkg::PID_W-1:0]    pid;
   logic [sst_pkg::PAGE_W-1:0]   page_addr;
   logic [sst_pkg::PID_W-1:0]    dest_pid;

   modport source (output valid, func, pid, page_addr, dest_pid, input ready);
   modport sink   (input valid, func, pid, page_addr, dest_pid, output ready);
endinterface

// ----- hdl/sst_rsp_if.sv -----
// Response channel of the swap slot table: one result per item.
interface sst_rsp_if;
   logic                         valid;
   logic                         ready;
   sst_pkg::status_type          status;
   logic [sst_pkg::SLOT_W-1:0]   slot;
   logic [sst_pkg::SLOT_W-1:0]   source_slot;
   logic [sst_pkg::CNT_W-1:0]    freed_count;
   logic [sst_pkg::CNT_W-1:0]    occupancy;
   logic                         last;

   modport source (output valid, status, slot, source_slot, freed_count, occupancy, last,
                   input ready);
   modport sink   (input valid, status, slot, source_slot, freed_count, occupancy, last,
                   output ready);
endinterface

// ----- hdl/swap_slot_table.sv -----
// Swap slot table: slot allocation, lookup, per-process release and copy.
//
// Requests arrive on req_port and results leave on rsp_port, both valid/ready
// channels where an item moves on a clock edge with valid and ready high.
// The block works on one request at a time and holds req_port.ready low
// until every result of the current request has been placed in the output
// register. Store, load and remove give one result; copy gives one result
// per copied page, the final one flagged by last, or a single result if it
// copies none; if free slots or the result budget run out, a last ST_FULL
// result follows the pages. A small sequencer walks the table one slot at a
// time. A free slot is only tested in a scan state; an occupied slot whose
// owner and page must be checked also passes an evaluate state, because the
// owner/page memory has a registered read port. A copy runs a source pointer
// and a free-slot pointer that only move forward.
// Reset clears the occupancy bits and the used count at once, so the table
// is empty on the first cycle after reset with no clearing pass.
// Results sit in an output register; when the receiver stalls, the
// sequencer waits at its next result and the table is left untouched.
module swap_slot_table (
   input  logic            clock,
   input  logic            reset,
   sst_req_if.sink         req_port,
   sst_rsp_if.source       rsp_port
);

   localparam int SLOT_W = sst_pkg::SLOT_W;
   localparam int CNT_W  = sst_pkg::CNT_W;
   localparam int PID_W  = sst_pkg::PID_W;
   localparam int PAGE_W = sst_pkg::PAGE_W;

   localparam logic [CNT_W-1:0] END_PTR   = CNT_W'(sst_pkg::SLOTS);
   localparam logic [CNT_W-1:0] PAIR_LIM  = CNT_W'(sst_pkg::MAX_RESULTS - 1);

   // One-hot sequencer states.
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_STORE = 11'b00000000010,
      S_LSRC  = 11'b00000000100,
      S_LEV   = 11'b00000001000,
      S_RSRC  = 11'b00000010000,
      S_REV   = 11'b00000100000,
      S_CSRC  = 11'b00001000000,
      S_CEV   = 11'b00010000000,
      S_CPEND = 11'b00100000000,
      S_CFREE = 11'b01000000000,
      S_FIN   = 11'b10000000000
   } state_type;

   state_type                 state_ff, state_in;

   // Latched request.
   logic [PID_W-1:0]          pid_ff, pid_in;
   logic [PAGE_W-1:0]         addr_ff, addr_in;
   logic [PID_W-1:0]          dpid_ff, dpid_in;

   // Scan pointers: source/lookup pointer and free-slot pointer.
   logic [CNT_W-1:0]          sptr_ff, sptr_in;
   logic [CNT_W-1:0]          fptr_ff, fptr_in;

   // Slots freed by remove, or pages copied by copy.
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // Table state: occupancy bits in flip-flops, owner/page in a memory.
   logic [sst_pkg::SLOTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   sst_pkg::entry_type        mem [sst_pkg::SLOTS];
   sst_pkg::entry_type        rd_data_ff;
   logic                      mem_we;
   sst_pkg::entry_type        mem_wd;

   // Copy pair that is waiting to learn whether it is the last one.
   logic                      pend_ff, pend_in;
   logic [SLOT_W-1:0]         pend_slot_ff, pend_slot_in;
   logic [SLOT_W-1:0]         pend_src_ff, pend_src_in;
   logic                      pend_to_fin_ff, pend_to_fin_in;

   // Final result of the current request.
   sst_pkg::status_type       fin_status_ff, fin_status_in;
   logic [SLOT_W-1:0]         fin_slot_ff, fin_slot_in;
   logic [SLOT_W-1:0]         fin_src_ff, fin_src_in;
   logic [CNT_W-1:0]          fin_freed_ff, fin_freed_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   sst_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [SLOT_W-1:0]         rsp_src_ff, rsp_src_in;
   logic [CNT_W-1:0]          rsp_freed_ff, rsp_freed_in;
   logic [CNT_W-1:0]          rsp_occ_ff, rsp_occ_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      out_free;
   logic                      req_take;
   logic                      pid_bad;
   logic                      dpid_bad;
   logic [SLOT_W-1:0]         sidx;
   logic [SLOT_W-1:0]         fidx;

   assign sidx     = sptr_ff[SLOT_W-1:0];
   assign fidx     = fptr_ff[SLOT_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_take       = req_port.valid && req_port.ready;

   // Process numbers at or above the process limit are rejected.
   assign pid_bad  = (32'(req_port.pid) >= 32'(sst_pkg::PROCS));
   assign dpid_bad = (32'(req_port.dest_pid) >= 32'(sst_pkg::PROCS));

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.slot        = rsp_slot_ff;
   assign rsp_port.source_slot = rsp_src_ff;
   assign rsp_port.freed_count = rsp_freed_ff;
   assign rsp_port.occupancy   = rsp_occ_ff;
   assign rsp_port.last        = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      pid_in         = pid_ff;
      addr_in        = addr_ff;
      dpid_in        = dpid_ff;
      sptr_in        = sptr_ff;
      fptr_in        = fptr_ff;
      cnt_in         = cnt_ff;
      used_in        = used_ff;
      occ_in         = occ_ff;
      pend_in        = pend_ff;
      pend_slot_in   = pend_slot_ff;
      pend_src_in    = pend_src_ff;
      pend_to_fin_in = pend_to_fin_ff;
      fin_status_in  = fin_status_ff;
      fin_slot_in    = fin_slot_ff;
      fin_src_in     = fin_src_ff;
      fin_freed_in   = fin_freed_ff;
      mem_we         = 1'b0;
      mem_wd         = '{owner: pid_ff, page: addr_ff};

      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pid_in        = req_port.pid;
               addr_in       = req_port.page_addr;
               dpid_in       = req_port.dest_pid;
               sptr_in       = '0;
               fptr_in       = '0;
               cnt_in        = '0;
               pend_in       = 1'b0;
               fin_status_in = sst_pkg::ST_BAD;
               fin_slot_in   = '0;
               fin_src_in    = '0;
               fin_freed_in  = '0;
               if (pid_bad) begin
                  state_in = S_FIN;
               end else begin
                  unique case (req_port.func)
                     sst_pkg::FUNC_STORE:  state_in = S_STORE;
                     sst_pkg::FUNC_LOAD:   state_in = S_LSRC;
                     sst_pkg::FUNC_REMOVE: state_in = S_RSRC;
                     sst_pkg::FUNC_COPY: begin
                        // Copying a process onto itself is refused.
                        if (dpid_bad || req_port.dest_pid == req_port.pid) begin
                           state_in = S_FIN;
                        end else begin
                           state_in = S_CSRC;
                        end
                     end
                     default: state_in = S_FIN;
                  endcase
               end
            end
         end

         S_STORE: begin
            if (fptr_ff == END_PTR) begin
               fin_status_in = sst_pkg::ST_FULL;
               state_in      = S_FIN;
            end else if (used_ff[fidx]) begin
               fptr_in = fptr_ff + 1'b1;
            end else begin
               mem_we        = 1'b1;
               used_in[fidx] = 1'b1;
               occ_in        = occ_ff + 1'b1;
               fin_status_in = sst_pkg::ST_OK;
               fin_slot_in   = fidx;
               state_in      = S_FIN;
            end
         end

         S_LSRC: begin
            if (sptr_ff == END_PTR) begin
               fin_status_in = sst_pkg::ST_NOT_FOUND;
               state_in      = S_FIN;
            end else if (used_ff[sidx]) begin
               state_in = S_LEV;
            end else begin
               sptr_in = sptr_ff + 1'b1;
            end
         end

         S_LEV: begin
            if (rd_data_ff.owner == pid_ff && rd_data_ff.page == addr_ff) begin
               used_in[sidx] = 1'b0;
               occ_in        = occ_ff - 1'b1;
               fin_status_in = sst_pkg::ST_OK;
               fin_slot_in   = sidx;
               state_in      = S_FIN;
            end else begin
               sptr_in  = sptr_ff + 1'b1;
               state_in = S_LSRC;
            end
         end

         S_RSRC: begin
            if (sptr_ff == END_PTR) begin
               fin_status_in = sst_pkg::ST_OK;
               fin_freed_in  = cnt_ff;
               state_in      = S_FIN;
            end else if (used_ff[sidx]) begin
               state_in = S_REV;
            end else begin
               sptr_in = sptr_ff + 1'b1;
            end
         end

         S_REV: begin
            if (rd_data_ff.owner == pid_ff) begin
               used_in[sidx] = 1'b0;
               occ_in        = occ_ff - 1'b1;
               cnt_in        = cnt_ff + 1'b1;
            end
            sptr_in  = sptr_ff + 1'b1;
            state_in = S_RSRC;
         end

         S_CSRC: begin
            if (sptr_ff == END_PTR) begin
               // End of scan: the held pair, if any, becomes the last result.
               fin_status_in = sst_pkg::ST_OK;
               fin_slot_in   = pend_ff ? pend_slot_ff : '0;
               fin_src_in    = pend_ff ? pend_src_ff : '0;
               fin_freed_in  = cnt_ff;
               pend_in       = 1'b0;
               state_in      = S_FIN;
            end else if (used_ff[sidx]) begin
               state_in = S_CEV;
            end else begin
               sptr_in = sptr_ff + 1'b1;
            end
         end

         S_CEV: begin
            if (rd_data_ff.owner == pid_ff) begin
               if (cnt_ff >= PAIR_LIM) begin
                  // Result budget spent: stop as if the table were full.
                  fin_status_in  = sst_pkg::ST_FULL;
                  fin_slot_in    = '0;
                  fin_src_in     = sidx;
                  fin_freed_in   = cnt_ff;
                  pend_to_fin_in = 1'b1;
                  state_in       = pend_ff ? S_CPEND : S_FIN;
               end else begin
                  pend_to_fin_in = 1'b0;
                  state_in       = pend_ff ? S_CPEND : S_CFREE;
               end
            end else begin
               sptr_in  = sptr_ff + 1'b1;
               state_in = S_CSRC;
            end
         end

         S_CPEND: begin
            // Another source page exists, so the held pair is not the last.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sst_pkg::ST_OK;
               rsp_slot_in   = pend_slot_ff;
               rsp_src_in    = pend_src_ff;
               rsp_freed_in  = '0;
               rsp_occ_in    = occ_ff;
               rsp_last_in   = 1'b0;
               pend_in       = 1'b0;
               state_in      = pend_to_fin_ff ? S_FIN : S_CFREE;
            end
         end

         S_CFREE: begin
            if (fptr_ff == END_PTR) begin
               fin_status_in = sst_pkg::ST_FULL;
               fin_slot_in   = '0;
               fin_src_in    = sidx;
               fin_freed_in  = cnt_ff;
               state_in      = S_FIN;
            end else if (used_ff[fidx]) begin
               fptr_in = fptr_ff + 1'b1;
            end else begin
               // Free slots are claimed in ascending order, so the free
               // pointer never has to look back.
               mem_we        = 1'b1;
               mem_wd        = '{owner: dpid_ff, page: rd_data_ff.page};
               used_in[fidx] = 1'b1;
               occ_in        = occ_ff + 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               pend_in       = 1'b1;
               pend_slot_in  = fidx;
               pend_src_in   = sidx;
               fptr_in       = fptr_ff + 1'b1;
               sptr_in       = sptr_ff + 1'b1;
               state_in      = S_CSRC;
            end
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fin_status_ff;
               rsp_slot_in   = fin_slot_ff;
               rsp_src_in    = fin_src_ff;
               rsp_freed_in  = fin_freed_ff;
               rsp_occ_in    = occ_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Owner/page memory: one write port, one registered read port that
   // follows the source pointer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fidx] <= mem_wd;
      end
      rd_data_ff <= mem[sidx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff         <= pid_in;
      addr_ff        <= addr_in;
      dpid_ff        <= dpid_in;
      sptr_ff        <= sptr_in;
      fptr_ff        <= fptr_in;
      cnt_ff         <= cnt_in;
      pend_slot_ff   <= pend_slot_in;
      pend_src_ff    <= pend_src_in;
      pend_to_fin_ff <= pend_to_fin_in;
      fin_status_ff  <= fin_status_in;
      fin_slot_ff    <= fin_slot_in;
      fin_src_ff     <= fin_src_in;
      fin_freed_ff   <= fin_freed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_src_ff     <= rsp_src_in;
      rsp_freed_ff   <= rsp_freed_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule
